[sv/bfrc_pkg.sv]
// Shared types, register indexes and helpers for the blit/fill clip and address front end.
// No dependencies; every other file of the block but bfrc_checker imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bfrc_pkg;

  // Coordinates and sizes inside the clip datapath, wide enough for every
  // intermediate value of the left and right cuts.
  localparam int unsigned CrdW = 20;
  localparam int unsigned DimW = 13;
  localparam int unsigned PitchW = 15;
  localparam int unsigned BppW = 3;
  localparam int unsigned OffW = 26;
  localparam int unsigned ColorW = 32;

  typedef logic signed [CrdW-1:0] crd_t;
  typedef logic [DimW-1:0] dim_t;
  typedef logic [PitchW-1:0] pitch_t;
  typedef logic [BppW-1:0] bpp_t;
  typedef logic [OffW-1:0] off_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_SRC_PITCH  = 3'd2;
  localparam logic [2:0] REG_DST_WIDTH  = 3'd3;
  localparam logic [2:0] REG_DST_HEIGHT = 3'd4;
  localparam logic [2:0] REG_DST_PITCH  = 3'd5;
  localparam logic [2:0] REG_BPP        = 3'd6;

  localparam bpp_t BPP_RESET = 3'd4;

  // One item in flight. The a side is the surface being clipped against in
  // the current cut, the b side is the paired origin that moves with it.
  typedef struct packed {
    logic              fill;
    logic              ok;
    crd_t              a_x;
    crd_t              a_y;
    crd_t              b_x;
    crd_t              b_y;
    crd_t              w;
    crd_t              h;
    logic [ColorW-1:0] color;
  } item_t;

  // Exchange the roles of the two surfaces.
  function automatic item_t bfrc_swap(item_t it);
    item_t r;
    r     = it;
    r.a_x = it.b_x;
    r.a_y = it.b_y;
    r.b_x = it.a_x;
    r.b_y = it.a_y;
    return r;
  endfunction

  // Zero-extend a surface dimension into the coordinate width.
  function automatic crd_t dim_to_crd(dim_t d);
    return $signed({{(CrdW-DimW){1'b0}}, d});
  endfunction

  // Sign-extend a 16-bit coordinate.
  function automatic crd_t sext16(logic [15:0] v);
    return $signed({{(CrdW-16){v[15]}}, v});
  endfunction

  // Zero-extend a 16-bit size.
  function automatic crd_t zext16(logic [15:0] v);
    return $signed({{(CrdW-16){1'b0}}, v});
  endfunction

endpackage

`default_nettype wire

[sv/blit_fill_rect_clip_address.sv]
// Throughput: one command per cycle; the seven stages each hold one item and move
// independently, so a stalled output only stops the stages behind it once they fill.
// Reset: all pipeline valid bits clear; surface registers reset to 0 and
// bytes_per_pixel to 4.
// Top level: configuration registers, command decode stage, and the clip/address pipeline.
// Depends on bfrc_pkg, bfrc_cut and bfrc_addr.
`timescale 1ns / 1ps
`default_nettype none

module blit_fill_rect_clip_address import bfrc_pkg::*; #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration write port.
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [14:0]  cfg_wdata_i,
  // Command stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // src_x[15:0], src_y[31:16], rect_w[47:32], rect_h[63:48],
  // dst_x[79:64], dst_y[95:80], fill_color[127:96]
  input  logic [127:0] s_axis_tdata,
  // func[0], use_src_rect[1], use_dst_rect[2]
  input  logic [2:0]   s_axis_tuser,
  // Result stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // clip_width[12:0], clip_height[25:13], src_offset[51:26],
  // dst_offset[77:52], fill_value[109:78], zero fill [111:110]
  output logic [111:0] m_axis_tdata,
  // draw[0]
  output logic         m_axis_tuser
);

  localparam logic [15:0] MaxDim = 16'(MAX_DIM);

  dim_t   src_w_q, src_h_q, dst_w_q, dst_h_q;
  pitch_t src_pitch_q, dst_pitch_q;
  bpp_t   bpp_q;
  dim_t   src_w_sat, src_h_sat, dst_w_sat, dst_h_sat;

  logic   v0_q, en0;
  item_t  dec_d, dec_q;
  logic   is_fill, has_src, has_dst, use_src;

  logic   sc_valid, sc_ready, dc_valid, dc_ready;
  item_t  sc_item, dc_in, dc_item, ad_in;

  logic   draw;
  dim_t   clip_w, clip_h;
  off_t   src_off, dst_off;
  logic [ColorW-1:0] fill_val;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q     <= '0;
      src_h_q     <= '0;
      src_pitch_q <= '0;
      dst_w_q     <= '0;
      dst_h_q     <= '0;
      dst_pitch_q <= '0;
      bpp_q       <= BPP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SRC_WIDTH:  src_w_q     <= cfg_wdata_i[DimW-1:0];
        REG_SRC_HEIGHT: src_h_q     <= cfg_wdata_i[DimW-1:0];
        REG_SRC_PITCH:  src_pitch_q <= cfg_wdata_i;
        REG_DST_WIDTH:  dst_w_q     <= cfg_wdata_i[DimW-1:0];
        REG_DST_HEIGHT: dst_h_q     <= cfg_wdata_i[DimW-1:0];
        REG_DST_PITCH:  dst_pitch_q <= cfg_wdata_i;
        REG_BPP:        bpp_q       <= cfg_wdata_i[BppW-1:0];
        default: ;
      endcase
    end
  end

  // Surface sizes saturate at the largest supported dimension.
  assign src_w_sat = ({3'b000, src_w_q} > MaxDim) ? MaxDim[DimW-1:0] : src_w_q;
  assign src_h_sat = ({3'b000, src_h_q} > MaxDim) ? MaxDim[DimW-1:0] : src_h_q;
  assign dst_w_sat = ({3'b000, dst_w_q} > MaxDim) ? MaxDim[DimW-1:0] : dst_w_q;
  assign dst_h_sat = ({3'b000, dst_h_q} > MaxDim) ? MaxDim[DimW-1:0] : dst_h_q;

  // Decode stage: resolve missing rectangles into origins and sizes.
  // A fill uses only the destination side and keeps its size for the destination cut.
  assign is_fill = s_axis_tuser[0];
  assign has_src = s_axis_tuser[1];
  assign has_dst = s_axis_tuser[2];
  assign use_src = has_src & ~is_fill;

  always_comb begin
    dec_d.fill  = is_fill;
    dec_d.ok    = 1'b1;
    dec_d.a_x   = use_src ? sext16(s_axis_tdata[15:0]) : '0;
    dec_d.a_y   = use_src ? sext16(s_axis_tdata[31:16]) : '0;
    dec_d.b_x   = has_dst ? sext16(s_axis_tdata[79:64]) : '0;
    dec_d.b_y   = has_dst ? sext16(s_axis_tdata[95:80]) : '0;
    dec_d.color = s_axis_tdata[127:96];
    if (is_fill) begin
      dec_d.w = has_dst ? zext16(s_axis_tdata[47:32]) : dim_to_crd(dst_w_sat);
      dec_d.h = has_dst ? zext16(s_axis_tdata[63:48]) : dim_to_crd(dst_h_sat);
    end else begin
      dec_d.w = has_src ? zext16(s_axis_tdata[47:32]) : dim_to_crd(src_w_sat);
      dec_d.h = has_src ? zext16(s_axis_tdata[63:48]) : dim_to_crd(src_h_sat);
    end
  end

  assign en0           = ~v0_q | sc_ready;
  assign s_axis_tready = en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en0) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0 && s_axis_tvalid) dec_q <= dec_d;
  end

  // Clip against the source surface; a fill passes through untouched.
  bfrc_cut u_src_cut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .skip_fill_i (1'b1),
    .lim_w_i     (src_w_sat),
    .lim_h_i     (src_h_sat),
    .valid_i     (v0_q),
    .ready_o     (sc_ready),
    .item_i      (dec_q),
    .valid_o     (sc_valid),
    .ready_i     (dc_ready),
    .item_o      (sc_item)
  );

  // Clip against the destination surface with the roles exchanged.
  assign dc_in = bfrc_swap(sc_item);

  logic ad_ready;

  bfrc_cut u_dst_cut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .skip_fill_i (1'b0),
    .lim_w_i     (dst_w_sat),
    .lim_h_i     (dst_h_sat),
    .valid_i     (sc_valid),
    .ready_o     (dc_ready),
    .item_i      (dc_in),
    .valid_o     (dc_valid),
    .ready_i     (ad_ready),
    .item_o      (dc_item)
  );

  // Back to source on the a side for address generation.
  assign ad_in = bfrc_swap(dc_item);

  bfrc_addr u_addr (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .src_pitch_i   (src_pitch_q),
    .dst_pitch_i   (dst_pitch_q),
    .bpp_i         (bpp_q),
    .valid_i       (dc_valid),
    .ready_o       (ad_ready),
    .item_i        (ad_in),
    .valid_o       (m_axis_tvalid),
    .ready_i       (m_axis_tready),
    .draw_o        (draw),
    .clip_width_o  (clip_w),
    .clip_height_o (clip_h),
    .src_offset_o  (src_off),
    .dst_offset_o  (dst_off),
    .fill_value_o  (fill_val)
  );

  assign m_axis_tuser = draw;
  assign m_axis_tdata = {2'b00, fill_val, dst_off, src_off, clip_h, clip_w};

endmodule

`default_nettype wire

[sv/bfrc_cut.sv]
// Two pipeline stages that clip a rectangle against one surface: left/top cut, then right/bottom.
// Depends on bfrc_pkg for the item type and coordinate helpers.
`timescale 1ns / 1ps
`default_nettype none

module bfrc_cut import bfrc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  skip_fill_i,
  input  dim_t  lim_w_i,
  input  dim_t  lim_h_i,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  output logic  valid_o,
  input  logic  ready_i,
  output item_t item_o
);

  logic  v1_q, v2_q;
  logic  en1, en2;
  logic  act1, act2;
  item_t s1_d, s1_q, s2_d, s2_q;
  crd_t  rem_w, rem_h;

  // Each stage loads when it is empty or the next one moves.
  assign en2     = ~v2_q | ready_i;
  assign en1     = ~v1_q | en2;
  assign ready_o = en1;
  assign valid_o = v2_q;
  assign item_o  = s2_q;

  // Left/top cut: a negative origin shortens the span and moves the paired origin.
  assign act1 = ~(skip_fill_i & item_i.fill);
  always_comb begin
    s1_d = item_i;
    if (act1 && ($signed(item_i.a_x) < 0)) begin
      s1_d.w   = item_i.w + item_i.a_x;
      s1_d.b_x = item_i.b_x - item_i.a_x;
      s1_d.a_x = '0;
    end
    if (act1 && ($signed(item_i.a_y) < 0)) begin
      s1_d.h   = item_i.h + item_i.a_y;
      s1_d.b_y = item_i.b_y - item_i.a_y;
      s1_d.a_y = '0;
    end
  end

  // Right/bottom cut: limit the span to what is left of the surface and clear ok if it is empty.
  assign act2  = ~(skip_fill_i & s1_q.fill);
  assign rem_w = dim_to_crd(lim_w_i) - s1_q.a_x;
  assign rem_h = dim_to_crd(lim_h_i) - s1_q.a_y;
  always_comb begin
    s2_d = s1_q;
    if (act2) begin
      if ($signed(rem_w) < $signed(s1_q.w)) begin
        s2_d.w = rem_w;
      end
      if ($signed(rem_h) < $signed(s1_q.h)) begin
        s2_d.h = rem_h;
      end
      s2_d.ok = s1_q.ok & ($signed(s2_d.w) > 0) & ($signed(s2_d.h) > 0);
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) s1_q <= s1_d;
    if (en2 && v1_q) s2_q <= s2_d;
  end

endmodule

`default_nettype wire

[sv/bfrc_addr.sv]
// Two pipeline stages that turn clipped origins into byte offsets and register the result item.
// Depends on bfrc_pkg; the a side of the incoming item is the source, the b side the destination.
`timescale 1ns / 1ps
`default_nettype none

module bfrc_addr import bfrc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pitch_t            src_pitch_i,
  input  pitch_t            dst_pitch_i,
  input  bpp_t              bpp_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  item_t             item_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic              draw_o,
  output dim_t              clip_width_o,
  output dim_t              clip_height_o,
  output off_t              src_offset_o,
  output off_t              dst_offset_o,
  output logic [ColorW-1:0] fill_value_o
);

  localparam int unsigned RowW = DimW + PitchW;
  localparam int unsigned ColW = DimW + BppW;

  logic              v1_q, v2_q;
  logic              en1, en2;
  logic [RowW-1:0]   sy_prod_d, sy_prod_q, dy_prod_d, dy_prod_q;
  logic [ColW-1:0]   sx_prod_d, sx_prod_q, dx_prod_d, dx_prod_q;
  logic              ok_q, fill_q;
  dim_t              w_q, h_q;
  logic [ColorW-1:0] color_q;
  off_t              src_sum, dst_sum;
  logic              draw_q;
  dim_t              clip_w_q, clip_h_q;
  off_t              src_off_q, dst_off_q;
  logic [ColorW-1:0] fill_val_q;

  assign en2     = ~v2_q | ready_i;
  assign en1     = ~v1_q | en2;
  assign ready_o = en1;
  assign valid_o = v2_q;

  // Row and column products. A drawn item has origins below the surface size,
  // so the low coordinate bits are exact; others are discarded later.
  assign sy_prod_d = {{PitchW{1'b0}}, item_i.a_y[DimW-1:0]} * {{DimW{1'b0}}, src_pitch_i};
  assign dy_prod_d = {{PitchW{1'b0}}, item_i.b_y[DimW-1:0]} * {{DimW{1'b0}}, dst_pitch_i};
  assign sx_prod_d = {{BppW{1'b0}}, item_i.a_x[DimW-1:0]} * {{DimW{1'b0}}, bpp_i};
  assign dx_prod_d = {{BppW{1'b0}}, item_i.b_x[DimW-1:0]} * {{DimW{1'b0}}, bpp_i};

  // Offsets wrap at the offset width.
  assign src_sum = sy_prod_q[OffW-1:0] + {{(OffW-ColW){1'b0}}, sx_prod_q};
  assign dst_sum = dy_prod_q[OffW-1:0] + {{(OffW-ColW){1'b0}}, dx_prod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  // Multiply stage.
  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      sy_prod_q <= sy_prod_d;
      dy_prod_q <= dy_prod_d;
      sx_prod_q <= sx_prod_d;
      dx_prod_q <= dx_prod_d;
      ok_q      <= item_i.ok;
      fill_q    <= item_i.fill;
      w_q       <= item_i.w[DimW-1:0];
      h_q       <= item_i.h[DimW-1:0];
      color_q   <= item_i.color;
    end
  end

  // Output stage: sum the offsets; an empty rectangle gets zero size and offsets, a fill no source offset.
  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      draw_q     <= ok_q;
      clip_w_q   <= ok_q ? w_q : '0;
      clip_h_q   <= ok_q ? h_q : '0;
      src_off_q  <= (ok_q && !fill_q) ? src_sum : '0;
      dst_off_q  <= ok_q ? dst_sum : '0;
      fill_val_q <= fill_q ? color_q : '0;
    end
  end

  assign draw_o        = draw_q;
  assign clip_width_o  = clip_w_q;
  assign clip_height_o = clip_h_q;
  assign src_offset_o  = src_off_q;
  assign dst_offset_o  = dst_off_q;
  assign fill_value_o  = fill_val_q;

endmodule

`default_nettype wire

[sv/bfrc_checker.sv]
// Port-level checks on the blit/fill clip front end, bound to the top level.
// Depends only on the top level's port list.
`timescale 1ns / 1ps
`default_nettype none

module bfrc_checker (
  input wire         clk_i,
  input wire         rst_ni,
  input wire         m_axis_tvalid,
  input wire         m_axis_tready,
  input wire [111:0] m_axis_tdata,
  input wire         m_axis_tuser
);

  // Nothing comes out while reset is held.
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result item valid during reset");

  // A stalled result item holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result item changed");

  // An empty rectangle carries zero size and zero offsets.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[77:0] == 78'd0)
    else $error("empty rectangle with nonzero size or offset");

  // A drawn rectangle has a nonzero width and height.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[12:0] != 13'd0 && m_axis_tdata[25:13] != 13'd0)
    else $error("drawn rectangle with zero size");

  // A nonzero fill value only comes from a fill, which has no source offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[109:78] != 32'd0 |-> m_axis_tdata[51:26] == 26'd0)
    else $error("fill item with a source offset");

endmodule

bind blit_fill_rect_clip_address bfrc_checker u_bfrc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
